// File: rtl/pfa_pkg.sv
`default_nettype none
package pfa_pkg;

  localparam int unsigned AddrW          = 40;
  localparam int unsigned CfgPagesW      = 13;
  localparam int unsigned CfgCountW      = 2;
  localparam int unsigned Regions        = 2;
  localparam int unsigned PageBytes      = 4096;
  localparam int unsigned PageShift      = $clog2(PageBytes);
  localparam int unsigned StackDepth     = 256;
  localparam int unsigned PagesPerRegion = 4096;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_REGION_COUNT  = 3'd0,
    CFG_REGION0_BASE  = 3'd1,
    CFG_REGION0_PAGES = 3'd2,
    CFG_REGION1_BASE  = 3'd3,
    CFG_REGION1_PAGES = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgCountW-1:0]              region_count;
    logic [Regions-1:0][AddrW-1:0]     base;
    logic [Regions-1:0][CfgPagesW-1:0] pages;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] page;
  } cmd_t;

  typedef struct packed {
    logic [AddrW-1:0] page_address;
    logic             ok;
    logic             page_used;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/pfa_ram.sv
`default_nettype none
module pfa_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr_i,
  input  wire logic [W-1:0]                  wdata_i,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr_i,
  output logic      [W-1:0]                  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/pfa_fifo.sv
`default_nettype none
module pfa_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic      [W-1:0] data_o,
  output logic              empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pfa_front.sv
`default_nettype none
module pfa_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [pfa_pkg::AddrW-1:0]   phys_address_i,
  input  wire logic                        hold_i,
  output logic                             full_o,
  output pfa_pkg::cmd_t                    cmd_o,
  output logic                             cmd_valid_o,
  input  wire logic                        cmd_pop_i
);

  pfa_pkg::cmd_t cmd_in;
  logic          q_full, q_empty;
  logic [$bits(pfa_pkg::cmd_t)-1:0] q_out;

  always_comb begin
    cmd_in.op   = pfa_pkg::op_e'(opcode_i);
    cmd_in.page = phys_address_i
                  & ~pfa_pkg::AddrW'(pfa_pkg::PageBytes - 1);
  end

  assign full_o      = q_full || hold_i;
  assign cmd_valid_o = !q_empty;
  assign cmd_o       = pfa_pkg::cmd_t'(q_out);

  pfa_fifo #(
    .W($bits(pfa_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !full_o),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .data_o (q_out),
    .empty_o(q_empty)
  );

endmodule
`default_nettype wire

// File: rtl/pfa_back.sv
`default_nettype none
module pfa_back #(
  parameter int unsigned STACK_DEPTH      = pfa_pkg::StackDepth,
  parameter int unsigned PAGES_PER_REGION = pfa_pkg::PagesPerRegion
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pfa_pkg::cfg_t cfg_i,
  input  wire pfa_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               init_busy_o,
  output pfa_pkg::res_t      res_o,
  output logic               res_push_o,
  input  wire logic          out_full_i
);

  localparam int unsigned AW   = pfa_pkg::AddrW;
  localparam int unsigned IW   = $clog2(PAGES_PER_REGION);
  localparam int unsigned CW   = $clog2(PAGES_PER_REGION + 1);
  localparam int unsigned BAW  = IW + 1;
  localparam int unsigned BD   = 2 << IW;
  localparam int unsigned KW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SH   = pfa_pkg::PageShift;

  typedef enum logic [10:0] {
    S_INIT_CLR     = 11'b00000000001,
    S_IDLE         = 11'b00000000010,
    S_START_CLR    = 11'b00000000100,
    S_LOOKUP       = 11'b00000001000,
    S_QUERY_EV     = 11'b00000010000,
    S_REFILL_BEGIN = 11'b00000100000,
    S_REFILL_RD    = 11'b00001000000,
    S_REFILL_EV    = 11'b00010000000,
    S_POP_CHK      = 11'b00100000000,
    S_POP_EV       = 11'b01000000000,
    S_RESULT       = 11'b10000000000
  } state_e;

  state_e                 state_q, state_d;
  pfa_pkg::op_e           op_q, op_d;
  logic [AW-1:0]          page_q, page_d;
  logic [BAW-1:0]         clr_q, clr_d;
  logic [1:0]             r_q, r_d;
  logic [CW-1:0]          p_q, p_d;
  logic                   take_q, take_d;
  logic [1:0][CW-1:0]     hint_q, hint_d;
  logic [1:0][AW-1:0]     ub_q, ub_d;
  logic [1:0][CW-1:0]     up_q, up_d;
  logic [KW-1:0]          count_q, count_d;
  pfa_pkg::res_t          res_q, res_d;

  logic [1:0]             nreg;
  logic [1:0][AW-1:0]     new_ub;
  logic [1:0][CW-1:0]     new_up;
  logic [1:0]             hit;
  logic                   lk_sel, rr;
  logic [IW-1:0]          lk_idx;
  logic [AW-1:0]          lk_diff;
  logic [KW-1:0]          cnt_m1, full_cnt;

  logic                   bm_we, bm_wdata, bm_rdata;
  logic [BAW-1:0]         bm_waddr, bm_raddr;
  logic                   st_we;
  logic [SW-1:0]          st_waddr, st_raddr;
  logic [AW-1:0]          st_wdata, st_rdata;

  assign nreg     = (cfg_i.region_count > 2'd2) ? 2'd2 : cfg_i.region_count;
  assign rr       = r_q[0];
  assign full_cnt = KW'(STACK_DEPTH);
  assign cnt_m1   = count_q - KW'(1);
  assign st_raddr = cnt_m1[SW-1:0];

  always_comb begin
    logic [31:0] n32, q32, res32, u32;
    for (int r = 0; r < 2; r++) begin
      n32   = 32'(cfg_i.pages[r]);
      q32   = (n32 * 32'd7) >> 3;
      res32 = (q32 + 32'(pfa_pkg::PageBytes - 1)) >> SH;
      u32   = (n32 > res32) ? (n32 - res32) : 32'd0;
      if (u32 > 32'(PAGES_PER_REGION)) begin
        u32 = 32'(PAGES_PER_REGION);
      end
      if (2'(r) < nreg) begin
        new_up[r] = CW'(u32);
        new_ub[r] = cfg_i.base[r] + (AW'(res32) << SH);
      end else begin
        new_up[r] = '0;
        new_ub[r] = '0;
      end
    end
  end

  always_comb begin
    logic [AW:0] lim;
    for (int r = 0; r < 2; r++) begin
      lim    = {1'b0, ub_q[r]} + ((AW + 1)'(up_q[r]) << SH);
      hit[r] = (2'(r) < nreg) && (page_q >= ub_q[r]) && ({1'b0, page_q} < lim);
    end
    lk_sel  = !hit[0];
    lk_diff = (page_q - ub_q[lk_sel]) >> SH;
    lk_idx  = lk_diff[IW-1:0];
  end

  assign bm_raddr = (state_q == S_LOOKUP) ? {lk_sel, lk_idx} : {rr, p_q[IW-1:0]};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    page_d      = page_q;
    clr_d       = clr_q;
    r_d         = r_q;
    p_d         = p_q;
    take_d      = take_q;
    hint_d      = hint_q;
    ub_d        = ub_q;
    up_d        = up_q;
    count_d     = count_q;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    bm_we       = 1'b0;
    bm_waddr    = clr_q;
    bm_wdata    = 1'b0;
    st_we       = 1'b0;
    st_waddr    = count_q[SW-1:0];
    st_wdata    = ub_q[rr] + (AW'(p_q) << SH);
    unique case (state_q)
      S_INIT_CLR, S_START_CLR: begin
        bm_we = 1'b1;
        clr_d = clr_q + BAW'(1);
        if (clr_q == '1) begin
          r_d     = 2'd0;
          state_d = (state_q == S_INIT_CLR) ? S_IDLE : S_REFILL_BEGIN;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          page_d    = cmd_i.page;
          res_d     = '0;
          unique case (cmd_i.op)
            pfa_pkg::OP_START: begin
              ub_d    = new_ub;
              up_d    = new_up;
              hint_d  = '0;
              count_d = '0;
              clr_d   = '0;
              state_d = S_START_CLR;
            end
            pfa_pkg::OP_ALLOC: begin
              r_d     = 2'd0;
              state_d = (count_q == '0) ? S_REFILL_BEGIN : S_POP_CHK;
            end
            pfa_pkg::OP_FREE, pfa_pkg::OP_QUERY: begin
              state_d = S_LOOKUP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOOKUP: begin
        res_d = '0;
        if (hit != 2'b00) begin
          res_d.ok = 1'b1;
          if (op_q == pfa_pkg::OP_FREE) begin
            bm_we    = 1'b1;
            bm_waddr = {lk_sel, lk_idx};
            if (CW'(lk_idx) < hint_q[lk_sel]) begin
              hint_d[lk_sel] = CW'(lk_idx);
            end
            state_d = S_RESULT;
          end else begin
            state_d = S_QUERY_EV;
          end
        end else begin
          state_d = S_RESULT;
        end
      end
      S_QUERY_EV: begin
        res_d.page_used = bm_rdata;
        state_d         = S_RESULT;
      end
      S_REFILL_BEGIN: begin
        if ((r_q < nreg) && (count_q != full_cnt)) begin
          p_d     = hint_q[rr];
          take_d  = 1'b1;
          state_d = S_REFILL_RD;
        end else if (op_q == pfa_pkg::OP_START) begin
          res_d   = '0;
          state_d = S_RESULT;
        end else begin
          state_d = S_POP_CHK;
        end
      end
      S_REFILL_RD: begin
        if (p_q >= up_q[rr]) begin
          hint_d[rr] = up_q[rr];
          r_d        = r_q + 2'd1;
          state_d    = S_REFILL_BEGIN;
        end else begin
          state_d = S_REFILL_EV;
        end
      end
      S_REFILL_EV: begin
        if (take_q) begin
          if (!bm_rdata) begin
            bm_we    = 1'b1;
            bm_waddr = {rr, p_q[IW-1:0]};
            bm_wdata = 1'b1;
            st_we    = 1'b1;
            count_d  = count_q + KW'(1);
            if (count_q + KW'(1) == full_cnt) begin
              take_d = 1'b0;
            end
          end
          p_d     = p_q + CW'(1);
          state_d = S_REFILL_RD;
        end else if (!bm_rdata) begin
          hint_d[rr] = p_q;
          r_d        = r_q + 2'd1;
          state_d    = S_REFILL_BEGIN;
        end else begin
          p_d     = p_q + CW'(1);
          state_d = S_REFILL_RD;
        end
      end
      S_POP_CHK: begin
        if (count_q != '0) begin
          count_d = cnt_m1;
          state_d = S_POP_EV;
        end else begin
          res_d   = '0;
          state_d = S_RESULT;
        end
      end
      S_POP_EV: begin
        res_d.page_address = st_rdata;
        res_d.ok           = 1'b1;
        res_d.page_used    = 1'b0;
        state_d            = S_RESULT;
      end
      S_RESULT: begin
        if (!out_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign init_busy_o = (state_q == S_INIT_CLR);
  assign res_o       = res_q;

  pfa_ram #(.W(1), .D(BD)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (bm_we),
    .waddr_i(bm_waddr),
    .wdata_i(bm_wdata),
    .raddr_i(bm_raddr),
    .rdata_o(bm_rdata)
  );

  pfa_ram #(.W(AW), .D(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    page_q <= page_d;
    p_q    <= p_d;
    take_q <= take_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_CLR;
      clr_q   <= '0;
      r_q     <= 2'd0;
      hint_q  <= '0;
      ub_q    <= '0;
      up_q    <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      r_q     <= r_d;
      hint_q  <= hint_d;
      ub_q    <= ub_d;
      up_q    <= up_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= full_cnt)
    else $error("Page stack count exceeds its depth.");

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !out_full_i)
    else $error("Result pushed into a full result queue.");

  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE) && cmd_valid_i)
    else $error("Command taken outside the idle state.");

  a_stack_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |=> count_q == $past(count_q) + KW'(1))
    else $error("Stack push did not advance the count.");

endmodule
`default_nettype wire

// File: rtl/page_frame_allocator_top.sv
`default_nettype none
// Physical page allocator with a queue interface on both sides. The back end
// handles one command at a time. A free passes a lookup state and the result
// state; a query adds an evaluate state after the lookup, and an allocate
// served from the page stack passes a pop check and a pop evaluate state.
// When the stack is empty an allocate refills it first, with a read and an
// evaluate state per bitmap bit scanned, as the bitmap memory returns one
// bit per read. A start clears all 8192 bitmap bits (default sizes) one bit
// per cycle, then refills the stack. After reset this clear runs with full held high.
module page_frame_allocator_top #(
  parameter int unsigned STACK_DEPTH      = pfa_pkg::StackDepth,
  parameter int unsigned PAGES_PER_REGION = pfa_pkg::PagesPerRegion
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_idx_i,
  input  wire logic [pfa_pkg::AddrW-1:0] cfg_data_i,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [pfa_pkg::AddrW-1:0] phys_address_i,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [pfa_pkg::AddrW-1:0]      page_address_o,
  output logic                           ok_o,
  output logic                           page_used_o
);

  pfa_pkg::cfg_t cfg_q, cfg_d;
  pfa_pkg::cmd_t cmd;
  pfa_pkg::res_t res_in, res_out;
  logic          cmd_valid, cmd_pop, init_busy, res_push, out_full;
  logic [$bits(pfa_pkg::res_t)-1:0] res_bits;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (pfa_pkg::cfg_idx_e'(cfg_idx_i))
        pfa_pkg::CFG_REGION_COUNT:  cfg_d.region_count = cfg_data_i[1:0];
        pfa_pkg::CFG_REGION0_BASE:  cfg_d.base[0]      = cfg_data_i;
        pfa_pkg::CFG_REGION0_PAGES: cfg_d.pages[0]     = cfg_data_i[12:0];
        pfa_pkg::CFG_REGION1_BASE:  cfg_d.base[1]      = cfg_data_i;
        pfa_pkg::CFG_REGION1_PAGES: cfg_d.pages[1]     = cfg_data_i[12:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .opcode_i      (opcode_i),
    .phys_address_i(phys_address_i),
    .hold_i        (init_busy),
    .full_o        (full),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  pfa_back #(
    .STACK_DEPTH     (STACK_DEPTH),
    .PAGES_PER_REGION(PAGES_PER_REGION)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .init_busy_o(init_busy),
    .res_o      (res_in),
    .res_push_o (res_push),
    .out_full_i (out_full)
  );

  pfa_fifo #(
    .W($bits(pfa_pkg::res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (res_bits),
    .empty_o(empty)
  );

  assign res_out        = pfa_pkg::res_t'(res_bits);
  assign page_address_o = res_out.page_address;
  assign ok_o           = res_out.ok;
  assign page_used_o    = res_out.page_used;

endmodule
`default_nettype wire
